>>> src/aarm_pkg.sv
package aarm_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 14;
    localparam int MAX_STEPS     = 24;

    // Angle units in 1/64 degree
    localparam int TURN_UNITS   = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    localparam int ANG_W = 34;  // Q30 angle / sin / cos working width
    localparam int XY_W  = 34;

    localparam logic [32:0] PI_Q30   = 33'd3373259426;
    localparam logic [33:0] GAIN_Q30 = 34'd652032874;
    localparam logic [33:0] ONE_Q30  = 34'd1073741824;

    // theta = (mag * PI + HALF_TURN/2) / HALF_TURN is split into
    // mag * PI_QUO + (mag * PI_REM + HALF_TURN/2) / HALF_TURN.
    // The small quotient (dividend < 2^26) uses a reciprocal that is exact
    // over that range.
    localparam int PI_QUO      = 292817;    // PI_Q30 / HALF_TURN
    localparam int PI_REM      = 7586;      // PI_Q30 mod HALF_TURN
    localparam int HALF_RECIP  = 95443718;  // ceil(2^40 / HALF_TURN)
    localparam int RECIP_SHIFT = 40;

    typedef struct packed {
        logic signed [ANG_W-1:0] z;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic                    neg_cos;
        logic signed [15:0]      ux;
        logic signed [15:0]      uy;
        logic signed [15:0]      uz;
    } cell_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0: r = 32'd843314857;
            1: r = 32'd497837829;
            2: r = 32'd263043837;
            3: r = 32'd133525159;
            4: r = 32'd67021687;
            5: r = 32'd33543516;
            6: r = 32'd16775851;
            7: r = 32'd8388437;
            8: r = 32'd4194283;
            9: r = 32'd2097149;
            default: r = 32'd1073741824 >> i;
        endcase
        return r;
    endfunction

endpackage

>>> src/aarm_prep.sv
// Angle wrap, quarter-turn fold and degree-to-radian conversion (3 stages)
module aarm_prep
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [15:0]   angle,
    input  logic signed [15:0]   ux,
    input  logic signed [15:0]   uy,
    input  logic signed [15:0]   uz,
    output aarm_pkg::cell_t      out
);
    localparam logic signed [16:0] TURN = 17'(aarm_pkg::TURN_UNITS);
    localparam logic signed [16:0] HALF = 17'(aarm_pkg::HALF_TURN);
    localparam logic signed [16:0] QTR  = 17'(aarm_pkg::QUARTER_TURN);

    logic signed [16:0] a_w;
    logic signed [16:0] a_f;
    logic               neg_w;
    logic [12:0]        mag_w;

    // stage 1 registers
    logic [12:0]        mag_reg;
    logic               sgn_reg;
    logic               neg1_reg;
    logic signed [15:0] ux1_reg, uy1_reg, uz1_reg;
    // stage 2 registers
    logic [31:0]        whole_reg;  // mag * PI_QUO
    logic [25:0]        part_reg;   // mag * PI_REM + HALF_TURN/2
    logic               sgn2_reg;
    logic               neg2_reg;
    logic signed [15:0] ux2_reg, uy2_reg, uz2_reg;

    logic [52:0]        part_prod;
    logic [30:0]        theta;
    aarm_pkg::cell_t    prep_next;

    // wrap and fold
    always_comb
    begin
        a_w = 17'(angle);
        if (a_w > HALF)
            a_w = a_w - TURN;
        else if (a_w < -HALF)
            a_w = a_w + TURN;
        neg_w = 1'b0;
        a_f   = a_w;
        if (a_w > QTR)
        begin
            a_f   = HALF - a_w;
            neg_w = 1'b1;
        end
        else if (a_w < -QTR)
        begin
            a_f   = -HALF - a_w;
            neg_w = 1'b1;
        end
        mag_w = a_f[16] ? 13'(-a_f) : 13'(a_f);
    end

    // divide by HALF_TURN: whole part plus reciprocal of the small remainder
    always_comb
    begin
        part_prod = 53'(part_reg) * 53'(aarm_pkg::HALF_RECIP);
        theta     = 31'(whole_reg) + 31'(part_prod >> aarm_pkg::RECIP_SHIFT);

        prep_next.z       = sgn2_reg ? -(aarm_pkg::ANG_W'(theta))
                                     :   aarm_pkg::ANG_W'(theta);
        prep_next.x       = aarm_pkg::GAIN_Q30;
        prep_next.y       = '0;
        prep_next.neg_cos = neg2_reg;
        prep_next.ux      = ux2_reg;
        prep_next.uy      = uy2_reg;
        prep_next.uz      = uz2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_w;
            sgn_reg  <= a_f[16];
            neg1_reg <= neg_w;
            ux1_reg  <= ux;
            uy1_reg  <= uy;
            uz1_reg  <= uz;

            whole_reg <= 32'(mag_reg) * 32'(aarm_pkg::PI_QUO);
            part_reg  <= 26'(mag_reg) * 26'(aarm_pkg::PI_REM)
                         + 26'(aarm_pkg::HALF_TURN / 2);
            sgn2_reg  <= sgn_reg;
            neg2_reg  <= neg1_reg;
            ux2_reg   <= ux1_reg;
            uy2_reg   <= uy1_reg;
            uz2_reg   <= uz1_reg;

            out <= prep_next;
        end
    end
endmodule

>>> src/aarm_cell.sv
// One CORDIC rotation step, registered
module aarm_cell
#(
    parameter int STEP = 0
)
(
    input  logic            clk,
    input  logic            en,
    input  aarm_pkg::cell_t in,
    output aarm_pkg::cell_t out
);
    localparam logic signed [aarm_pkg::ANG_W-1:0] ATAN =
        aarm_pkg::ANG_W'(aarm_pkg::atan_q30(STEP));

    logic signed [aarm_pkg::XY_W-1:0] dx, dy;
    aarm_pkg::cell_t step_next;

    assign dx = in.y >>> STEP;
    assign dy = in.x >>> STEP;

    // rotate toward zero residual angle
    always_comb
    begin
        step_next = in;
        if (!in.z[aarm_pkg::ANG_W-1])
        begin
            step_next.x = in.x - dx;
            step_next.y = in.y + dy;
            step_next.z = in.z - ATAN;
        end
        else
        begin
            step_next.x = in.x + dx;
            step_next.y = in.y - dy;
            step_next.z = in.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out <= step_next;
    end
endmodule

>>> src/aarm_matrix.sv
// Rodrigues assembly: products, sums, rounding, saturation (3 stages)
module aarm_matrix
#(
    parameter int FRACTION_BITS = aarm_pkg::FRACTION_BITS
)
(
    input  logic              clk,
    input  logic              en,
    input  aarm_pkg::cell_t   in,
    output logic [143:0]      mat
);
    typedef logic signed [63:0] acc_t;

    logic signed [33:0] c, omc;
    logic signed [15:0] u [3];

    // stage 1: axis pair products and axis*sin
    logic signed [31:0] pp_reg [3][3];
    logic signed [49:0] us_reg [3];
    logic signed [33:0] c1_reg, omc1_reg;
    // stage 2: pair * (1-cos) >> F
    acc_t               at_reg [3][3];
    acc_t               cs_reg;
    logic signed [49:0] us2_reg [3];

    acc_t acc [9];
    acc_t rnd [9];

    always_comb
    begin
        c    = in.neg_cos ? -in.x : in.x;
        omc  = aarm_pkg::ONE_Q30 - c;
        u[0] = in.ux;
        u[1] = in.uy;
        u[2] = in.uz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    pp_reg[i][j] <= 32'(u[i]) * 32'(u[j]);
                us_reg[i] <= 50'(u[i]) * 50'(in.y);
            end
            c1_reg   <= c;
            omc1_reg <= omc;

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    at_reg[i][j] <= (64'(pp_reg[i][j]) * 64'(omc1_reg)) >>> FRACTION_BITS;
                us2_reg[i] <= us_reg[i];
            end
            cs_reg <= 64'(c1_reg) <<< FRACTION_BITS;
        end
    end

    // sums and rounding
    always_comb
    begin
        acc[0] = at_reg[0][0] + cs_reg;
        acc[1] = at_reg[0][1] - 64'(us2_reg[2]);
        acc[2] = at_reg[0][2] + 64'(us2_reg[1]);
        acc[3] = at_reg[0][1] + 64'(us2_reg[2]);
        acc[4] = at_reg[1][1] + cs_reg;
        acc[5] = at_reg[1][2] - 64'(us2_reg[0]);
        acc[6] = at_reg[0][2] - 64'(us2_reg[1]);
        acc[7] = at_reg[1][2] + 64'(us2_reg[0]);
        acc[8] = at_reg[2][2] + cs_reg;
        for (int k = 0; k < 9; k++)
            rnd[k] = (acc[k] + 64'sd536870912) >>> 30;
    end

    // saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                if (rnd[k] > 64'sd32767)
                    mat[k*16 +: 16] <= 16'h7fff;
                else if (rnd[k] < -64'sd32768)
                    mat[k*16 +: 16] <= 16'h8000;
                else
                    mat[k*16 +: 16] <= rnd[k][15:0];
            end
        end
    end
endmodule

>>> src/axis_angle_rotation_matrix.sv
// Channel  Dir  tdata fields (low bit first)
// s_axis   in   angle_deg, axis_x, axis_y, axis_z (16 b each)
// m_axis   out  m00 m01 m02 m10 m11 m12 m20 m21 m22 (16 b each)
// One transfer per cycle sustained, data passing the prep, CORDIC cell
// and matrix registers in order. The whole pipe advances when the
// output register is empty or being taken; a stall on m_axis freezes it.
// Reset clears only the valid bits of the pipe.
module axis_angle_rotation_matrix
#(
    parameter int CORDIC_STEPS  = aarm_pkg::CORDIC_STEPS,
    parameter int FRACTION_BITS = aarm_pkg::FRACTION_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // angle_deg, axis_x, axis_y, axis_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // m00 .. m22
);
    localparam int DEPTH = CORDIC_STEPS + 6;

    logic             en;
    logic [DEPTH-1:0] vld_reg;
    aarm_pkg::cell_t  chain [CORDIC_STEPS+1];

    assign en            = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    aarm_prep u_prep
    (
        .clk   (clk),
        .en    (en),
        .angle (s_axis_tdata[15:0]),
        .ux    (s_axis_tdata[31:16]),
        .uy    (s_axis_tdata[47:32]),
        .uz    (s_axis_tdata[63:48]),
        .out   (chain[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        aarm_cell #(.STEP(g)) u_cell
        (
            .clk (clk),
            .en  (en),
            .in  (chain[g]),
            .out (chain[g+1])
        );
    end

    aarm_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_mat
    (
        .clk (clk),
        .en  (en),
        .in  (chain[CORDIC_STEPS]),
        .mat (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result lost under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
`endif
endmodule
